// ----- design/i2cm_pkg.sv -----
package i2cm_pkg;

  // Sequencer phases of one bus command.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST1,
    PH_ST2,
    PH_SP1,
    PH_SP2,
    PH_WA1,
    PH_WA2,
    PH_POLL,
    PH_WR_LO,
    PH_WR_HI,
    PH_WR_END,
    PH_RD_LO,
    PH_RD_HI,
    PH_AK_LO,
    PH_AK_HI
  } phase_t;

  // Command codes on the operation field.
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam int DELAY_W   = 16;
  localparam int TIMEOUT_W = 8;
  localparam int BYTE_W    = 8;
  localparam int BITCNT_W  = 4;

  localparam logic [DELAY_W-1:0]   DELAY_RESET   = 16'd2;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd250;
  localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE = 4'd8;

  // Register file: one register per word address, read as a 32-bit word.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_DELAY_TICKS = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

endpackage

// ----- design/i2c_master_bit_engine.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// in       | in_valid / in_ready  | operation, tx_byte, send_ack, sda_in
// out      | out_valid / out_ready| scl_level, sda_level, sda_enable, busy_res,
//          |                      | done_res, rx_byte, ack_error
// config   | APB psel/penable     | paddr 0: delay_ticks, paddr 4: ack_timeout
//
// Each input word is one bus tick: the sequencer state and the result
// register load at the same edge when the word is accepted. A new word
// is taken every cycle while the result register is empty or being drained,
// so throughput is one word per clock. Reset (rst, synchronous) returns the
// sequencer to idle with SCL and SDA driven high and restores the register
// defaults. A stall on the output holds the result and stops input intake.
module i2c_master_bit_engine (
  input  logic                              clk,
  input  logic                              rst,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        operation,
  input  logic [i2cm_pkg::BYTE_W-1:0]       tx_byte,
  input  logic                              send_ack,
  input  logic                              sda_in,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              scl_level,
  output logic                              sda_level,
  output logic                              sda_enable,
  output logic                              busy_res,
  output logic                              done_res,
  output logic [i2cm_pkg::BYTE_W-1:0]       rx_byte,
  output logic                              ack_error,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cm_pkg::PADDR_W-1:0]      paddr,
  input  logic [i2cm_pkg::PDATA_W-1:0]      pwdata,
  output logic [i2cm_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  // Configuration registers.
  logic [i2cm_pkg::DELAY_W-1:0]   delay_ticks;
  logic [i2cm_pkg::TIMEOUT_W-1:0] ack_timeout;

  // Sequencer state.
  i2cm_pkg::phase_t               phase, phase_next;
  logic [i2cm_pkg::BITCNT_W-1:0]  bit_count, bit_count_next;
  logic [i2cm_pkg::BYTE_W-1:0]    shift_reg, shift_reg_next;
  logic [i2cm_pkg::DELAY_W-1:0]   delay_count, delay_count_next;
  logic [i2cm_pkg::TIMEOUT_W-1:0] poll_count, poll_count_next;
  logic                           scl_r, scl_r_next;
  logic                           sda_r, sda_r_next;
  logic                           en_r, en_r_next;
  logic                           ack_choice, ack_choice_next;
  logic                           error_flag, error_flag_next;
  logic [i2cm_pkg::BYTE_W-1:0]    rx_last, rx_last_next;
  logic                           done_next;

  logic                           in_fire;
  logic                           cfg_write;
  logic [i2cm_pkg::DELAY_W-1:0]   hold_load;
  logic [i2cm_pkg::BITCNT_W-1:0]  bit_count_inc;

  // The result register parts the two channels: input is taken whenever the
  // pending result is absent or leaves at this same edge.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      i2cm_pkg::REG_DELAY_TICKS: begin
        prdata = {{(i2cm_pkg::PDATA_W-i2cm_pkg::DELAY_W){1'b0}}, delay_ticks};
      end
      i2cm_pkg::REG_ACK_TIMEOUT: begin
        prdata = {{(i2cm_pkg::PDATA_W-i2cm_pkg::TIMEOUT_W){1'b0}}, ack_timeout};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= i2cm_pkg::DELAY_RESET;
      ack_timeout <= i2cm_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        i2cm_pkg::REG_DELAY_TICKS: begin
          delay_ticks <= pwdata[i2cm_pkg::DELAY_W-1:0];
        end
        i2cm_pkg::REG_ACK_TIMEOUT: begin
          ack_timeout <= pwdata[i2cm_pkg::TIMEOUT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A hold keeps the lines for delay_ticks ticks including the tick they
  // change on; a programmed delay of zero behaves as one.
  assign hold_load     = (delay_ticks == '0) ? '0 : delay_ticks - 1'b1;
  assign bit_count_inc = bit_count + 1'b1;

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    poll_count_next  = poll_count;
    scl_r_next       = scl_r;
    sda_r_next       = sda_r;
    en_r_next        = en_r;
    ack_choice_next  = ack_choice;
    error_flag_next  = error_flag;
    rx_last_next     = rx_last;
    done_next        = 1'b0;

    if (phase == i2cm_pkg::PH_IDLE) begin
      // New commands are only looked at while idle; unknown codes do nothing.
      case (operation)
        i2cm_pkg::OP_START: begin
          {scl_r_next, sda_r_next, en_r_next} = 3'b111;
          delay_count_next = hold_load;
          phase_next       = i2cm_pkg::PH_ST1;
        end
        i2cm_pkg::OP_STOP: begin
          {scl_r_next, sda_r_next, en_r_next} = 3'b001;
          delay_count_next = hold_load;
          phase_next       = i2cm_pkg::PH_SP1;
        end
        i2cm_pkg::OP_WRITE: begin
          bit_count_next   = '0;
          shift_reg_next   = {tx_byte[i2cm_pkg::BYTE_W-2:0], 1'b0};
          scl_r_next       = 1'b0;
          sda_r_next       = tx_byte[i2cm_pkg::BYTE_W-1];
          en_r_next        = 1'b1;
          delay_count_next = hold_load;
          phase_next       = i2cm_pkg::PH_WR_LO;
        end
        i2cm_pkg::OP_WAIT: begin
          error_flag_next  = 1'b0;
          poll_count_next  = '0;
          sda_r_next       = 1'b1;
          en_r_next        = 1'b0;
          delay_count_next = hold_load;
          phase_next       = i2cm_pkg::PH_WA1;
        end
        i2cm_pkg::OP_READ: begin
          ack_choice_next  = send_ack;
          shift_reg_next   = '0;
          bit_count_next   = '0;
          {scl_r_next, sda_r_next, en_r_next} = 3'b010;
          delay_count_next = hold_load;
          phase_next       = i2cm_pkg::PH_RD_LO;
        end
        default: begin
        end
      endcase
    end else if (phase == i2cm_pkg::PH_POLL || (phase == i2cm_pkg::PH_WA2 &&
                 delay_count == '0)) begin
      // Acknowledge poll: one sample of SDA per tick. Low means the slave
      // acknowledged; too many high samples raise the error and force a stop.
      phase_next = i2cm_pkg::PH_POLL;
      if (!sda_in) begin
        scl_r_next = 1'b0;
        phase_next = i2cm_pkg::PH_IDLE;
        done_next  = 1'b1;
      end else if (poll_count >= ack_timeout) begin
        error_flag_next  = 1'b1;
        {scl_r_next, sda_r_next, en_r_next} = 3'b001;
        delay_count_next = hold_load;
        phase_next       = i2cm_pkg::PH_SP1;
      end else begin
        poll_count_next = poll_count + 1'b1;
      end
    end else if (delay_count != '0) begin
      delay_count_next = delay_count - 1'b1;
    end else begin
      case (phase)
        i2cm_pkg::PH_ST1: begin
          sda_r_next       = 1'b0;
          delay_count_next = hold_load;
          phase_next       = i2cm_pkg::PH_ST2;
        end
        i2cm_pkg::PH_ST2: begin
          scl_r_next = 1'b0;
          phase_next = i2cm_pkg::PH_IDLE;
          done_next  = 1'b1;
        end
        i2cm_pkg::PH_SP1: begin
          {scl_r_next, sda_r_next, en_r_next} = 3'b111;
          delay_count_next = hold_load;
          phase_next       = i2cm_pkg::PH_SP2;
        end
        i2cm_pkg::PH_SP2: begin
          phase_next = i2cm_pkg::PH_IDLE;
          done_next  = 1'b1;
        end
        i2cm_pkg::PH_WA1: begin
          scl_r_next       = 1'b1;
          delay_count_next = hold_load;
          phase_next       = i2cm_pkg::PH_WA2;
        end
        i2cm_pkg::PH_WR_LO: begin
          scl_r_next       = 1'b1;
          delay_count_next = hold_load;
          phase_next       = i2cm_pkg::PH_WR_HI;
        end
        i2cm_pkg::PH_WR_HI: begin
          // Falling SCL: present the next data bit, or finish after bit eight.
          bit_count_next   = bit_count_inc;
          scl_r_next       = 1'b0;
          delay_count_next = hold_load;
          if (bit_count_inc < i2cm_pkg::BITS_PER_BYTE) begin
            sda_r_next     = shift_reg[i2cm_pkg::BYTE_W-1];
            shift_reg_next = {shift_reg[i2cm_pkg::BYTE_W-2:0], 1'b0};
            phase_next     = i2cm_pkg::PH_WR_LO;
          end else begin
            phase_next     = i2cm_pkg::PH_WR_END;
          end
        end
        i2cm_pkg::PH_WR_END: begin
          phase_next = i2cm_pkg::PH_IDLE;
          done_next  = 1'b1;
        end
        i2cm_pkg::PH_RD_LO: begin
          // Rising SCL: sample the data bit.
          scl_r_next       = 1'b1;
          shift_reg_next   = {shift_reg[i2cm_pkg::BYTE_W-2:0], sda_in};
          delay_count_next = hold_load;
          phase_next       = i2cm_pkg::PH_RD_HI;
        end
        i2cm_pkg::PH_RD_HI: begin
          bit_count_next   = bit_count_inc;
          delay_count_next = hold_load;
          if (bit_count_inc < i2cm_pkg::BITS_PER_BYTE) begin
            scl_r_next = 1'b0;
            phase_next = i2cm_pkg::PH_RD_LO;
          end else begin
            // Byte complete: drive ACK (low) or NACK (high) on SDA.
            rx_last_next = shift_reg;
            scl_r_next   = 1'b0;
            sda_r_next   = !ack_choice;
            en_r_next    = 1'b1;
            phase_next   = i2cm_pkg::PH_AK_LO;
          end
        end
        i2cm_pkg::PH_AK_LO: begin
          scl_r_next       = 1'b1;
          delay_count_next = hold_load;
          phase_next       = i2cm_pkg::PH_AK_HI;
        end
        i2cm_pkg::PH_AK_HI: begin
          scl_r_next = 1'b0;
          phase_next = i2cm_pkg::PH_IDLE;
          done_next  = 1'b1;
        end
        default: begin
          phase_next = i2cm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Sequencer state and result register load together on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= i2cm_pkg::PH_IDLE;
      bit_count   <= '0;
      shift_reg   <= '0;
      delay_count <= '0;
      poll_count  <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      en_r        <= 1'b1;
      ack_choice  <= 1'b0;
      error_flag  <= 1'b0;
      rx_last     <= '0;
      done_res    <= 1'b0;
      busy_res    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        phase       <= phase_next;
        bit_count   <= bit_count_next;
        shift_reg   <= shift_reg_next;
        delay_count <= delay_count_next;
        poll_count  <= poll_count_next;
        scl_r       <= scl_r_next;
        sda_r       <= sda_r_next;
        en_r        <= en_r_next;
        ack_choice  <= ack_choice_next;
        error_flag  <= error_flag_next;
        rx_last     <= rx_last_next;
        done_res    <= done_next;
        busy_res    <= (phase_next != i2cm_pkg::PH_IDLE);
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  // The line and status registers only change on an accepted word, so they
  // double as the payload of the pending result.
  assign scl_level  = scl_r;
  assign sda_level  = sda_r;
  assign sda_enable = en_r;
  assign rx_byte    = rx_last;
  assign ack_error  = error_flag;

endmodule
